### rtl/core/socks5_udp_header_deframer_top_assert.svh
// Assertion macros used by the relay header deframer parse module
`ifndef SOCKS5_UDP_HEADER_DEFRAMER_TOP_ASSERT_SVH
`define SOCKS5_UDP_HEADER_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst
`define S5UDP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("s5udp assertion failed");

// Next-cycle implication, sampled on clk and disabled during rst
`define S5UDP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("s5udp assertion failed");

`endif

### rtl/core/s5udp_pkg.sv
// Types and constants of the relay datagram header deframer
package s5udp_pkg;

  localparam int unsigned MaxDatagram = 65536;
  localparam int PosW = $clog2(MaxDatagram + 1);
  localparam int CmpW = PosW + 1;
  localparam int LimW = 17;
  localparam int HdrW = 9;

  localparam logic [PosW-1:0] MAX_POS    = PosW'(MaxDatagram);
  localparam logic [PosW-1:0] MIN_LENGTH = PosW'(10);
  localparam logic [PosW-1:0] POS_FRAG   = PosW'(2);
  localparam logic [PosW-1:0] POS_KIND   = PosW'(3);
  localparam logic [PosW-1:0] POS_ADDR   = PosW'(4);
  localparam logic [PosW-1:0] POS_ADDR_END = PosW'(8);

  localparam logic [7:0] KIND_IPV4   = 8'd1;
  localparam logic [7:0] KIND_DOMAIN = 8'd3;
  localparam logic [7:0] KIND_IPV6   = 8'd4;

  localparam logic [HdrW-1:0] HDR_IPV4   = HdrW'(10);
  localparam logic [HdrW-1:0] HDR_DOMAIN = HdrW'(7);
  localparam logic [HdrW-1:0] HDR_IPV6   = HdrW'(22);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_FRAG    = 3'd2,
    ST_TRUNC   = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef struct packed {
    logic [LimW-1:0] buffer_limit;
    logic            last_byte;
    logic [7:0]      rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [LimW-1:0] copied_length;
    logic [15:0]     source_port;
    logic [31:0]     source_address;
    status_t         frame_status;
    logic            frame_done;
    logic            payload_valid;
    logic [7:0]      payload_byte;
  } result_t;

endpackage

### rtl/core/s5udp_in_reg.sv
// Input register stage of the deframer, one item deep with full throughput while the held item is taken
module s5udp_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  s5udp_pkg::in_item_t in_item,
  input  logic                take,
  output logic                held_valid,
  output s5udp_pkg::in_item_t held_item
);

  logic vld;
  s5udp_pkg::in_item_t item;

  // accept when empty or when the held item moves on in this cycle
  assign in_ready   = !vld || take;
  assign held_valid = vld;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

### rtl/core/s5udp_parse.sv
// Header parse state and result build for one datagram byte
module s5udp_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  s5udp_pkg::in_item_t item,
  output logic                res_valid,
  output s5udp_pkg::result_t  res
);

  `include "socks5_udp_header_deframer_top_assert.svh"

  logic [s5udp_pkg::PosW-1:0] pos;
  logic [7:0]                 kind;
  logic [s5udp_pkg::HdrW-1:0] hlen;
  logic [31:0]                addr;
  logic [15:0]                port;
  logic [s5udp_pkg::LimW-1:0] limit;
  logic [s5udp_pkg::LimW-1:0] count;
  s5udp_pkg::status_t         err;

  logic [s5udp_pkg::PosW-1:0] pos_next;
  logic [7:0]                 kind_next;
  logic [s5udp_pkg::HdrW-1:0] hlen_next;
  logic [31:0]                addr_next;
  logic [15:0]                port_next;
  logic [s5udp_pkg::LimW-1:0] limit_next;
  logic [s5udp_pkg::LimW-1:0] count_next;
  s5udp_pkg::status_t         err_next;

  logic                       first;
  logic                       in_range;
  logic                       pay;
  logic [s5udp_pkg::PosW-1:0] len;
  logic [s5udp_pkg::CmpW-1:0] p_wide;
  logic [s5udp_pkg::CmpW-1:0] h_wide;
  s5udp_pkg::status_t         status;

  always_comb begin
    first    = (pos == '0);
    in_range = (pos < s5udp_pkg::MAX_POS);
    pay      = 1'b0;

    // restart the frame state on the first byte
    limit_next = first ? item.buffer_limit : limit;
    kind_next  = first ? 8'd0 : kind;
    hlen_next  = first ? '0 : hlen;
    addr_next  = first ? 32'd0 : addr;
    port_next  = first ? 16'd0 : port;
    count_next = first ? '0 : count;
    err_next   = first ? s5udp_pkg::ST_OK : err;

    p_wide = s5udp_pkg::CmpW'(pos);
    h_wide = s5udp_pkg::CmpW'(hlen_next);

    if (in_range) begin
      if (pos == s5udp_pkg::POS_FRAG) begin
        if (item.rx_byte != 8'd0) begin
          err_next = s5udp_pkg::ST_FRAG;
        end
      end else if (pos == s5udp_pkg::POS_KIND) begin
        kind_next = item.rx_byte;
        case (item.rx_byte)
          s5udp_pkg::KIND_IPV4:   hlen_next = s5udp_pkg::HDR_IPV4;
          s5udp_pkg::KIND_DOMAIN: hlen_next = s5udp_pkg::HDR_DOMAIN;
          s5udp_pkg::KIND_IPV6:   hlen_next = s5udp_pkg::HDR_IPV6;
          default: begin
            if (err_next == s5udp_pkg::ST_OK) begin
              err_next = s5udp_pkg::ST_UNKNOWN;
            end
          end
        endcase
      end else if (pos == s5udp_pkg::POS_ADDR && kind_next == s5udp_pkg::KIND_DOMAIN) begin
        hlen_next = s5udp_pkg::HDR_DOMAIN + s5udp_pkg::HdrW'(item.rx_byte);
      end else if (pos >= s5udp_pkg::POS_ADDR && hlen_next != '0) begin
        if (kind_next == s5udp_pkg::KIND_IPV4 && pos < s5udp_pkg::POS_ADDR_END) begin
          addr_next = {addr_next[23:0], item.rx_byte};
        end
        // the two bytes just before the payload carry the port
        if (p_wide + s5udp_pkg::CmpW'(2) == h_wide ||
            p_wide + s5udp_pkg::CmpW'(1) == h_wide) begin
          port_next = {port_next[7:0], item.rx_byte};
        end
        if (p_wide >= h_wide && err_next == s5udp_pkg::ST_OK &&
            count_next < limit_next) begin
          pay        = 1'b1;
          count_next = count_next + s5udp_pkg::LimW'(1);
        end
      end
    end

    // saturate the position so oversize bytes are dropped
    len = in_range ? pos + s5udp_pkg::PosW'(1) : pos;
    pos_next = item.last_byte ? '0 : len;

    if (len < s5udp_pkg::MIN_LENGTH) begin
      status = s5udp_pkg::ST_SHORT;
    end else if (err_next != s5udp_pkg::ST_OK) begin
      status = err_next;
    end else if (hlen_next == '0 ||
                 s5udp_pkg::CmpW'(len) < s5udp_pkg::CmpW'(hlen_next)) begin
      status = s5udp_pkg::ST_TRUNC;
    end else begin
      status = s5udp_pkg::ST_OK;
    end

    res_valid          = pay || item.last_byte;
    res.payload_byte   = pay ? item.rx_byte : 8'd0;
    res.payload_valid  = pay;
    res.frame_done     = item.last_byte;
    res.frame_status   = item.last_byte ? status : s5udp_pkg::ST_OK;
    res.source_address = 32'd0;
    res.source_port    = 16'd0;
    res.copied_length  = '0;
    if (item.last_byte && status == s5udp_pkg::ST_OK) begin
      res.source_address = addr_next;
      res.source_port    = port_next;
      res.copied_length  = count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      kind  <= 8'd0;
      hlen  <= '0;
      addr  <= 32'd0;
      port  <= 16'd0;
      limit <= '0;
      count <= '0;
      err   <= s5udp_pkg::ST_OK;
    end else if (step) begin
      pos   <= pos_next;
      kind  <= kind_next;
      hlen  <= hlen_next;
      addr  <= addr_next;
      port  <= port_next;
      limit <= limit_next;
      count <= count_next;
      err   <= err_next;
    end
  end

  `S5UDP_ASSERT_IMP(a_bare_result_closes, step && res_valid && !res.payload_valid, res.frame_done)
  `S5UDP_ASSERT_IMP(a_error_hides_fields,
    step && res.frame_done && res.frame_status != s5udp_pkg::ST_OK,
    res.source_address == 32'd0 && res.source_port == 16'd0 && res.copied_length == '0)
  `S5UDP_ASSERT_NXT(a_position_moves, step && !item.last_byte, pos != '0)

endmodule

### rtl/core/s5udp_out_reg.sv
// Result register of the deframer, loaded as the input stage moves on
module s5udp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  logic               res_valid,
  input  s5udp_pkg::result_t res,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               can_load,
  output s5udp_pkg::result_t out_res
);

  logic               vld;
  s5udp_pkg::result_t data;

  assign can_load  = !vld || out_ready;
  assign out_valid = vld;
  assign out_res   = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= res_valid;
    end else if (out_ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res_valid) begin
      data <= res;
    end
  end

endmodule

### rtl/core/socks5_udp_header_deframer_top.sv
// Relay datagram header deframer: one datagram byte per transfer in, payload
// bytes and a closing status out. Each accepted byte is parsed in a single
// pass between the input register and the result register, so the block takes
// one byte every cycle unless m_axis_tready stalls it; a result enters the
// result register as its byte leaves the input register. A byte yields a
// result only if it is a copied payload byte or the datagram's last byte;
// header and dropped bytes yield none. Payload bytes are passed tentatively:
// a nonzero frame_status on the closing result voids the whole datagram.
// s_axis_tready follows m_axis_tready in the same cycle while both are full.
module socks5_udp_header_deframer_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [7:0] rx_byte, [24:8] buffer_limit, rest zero
  input  logic        s_axis_tlast,  // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] payload_byte, [10:8] frame_status, [42:11] source_address,
  // [58:43] source_port, [75:59] copied_length, rest zero
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tuser,  // payload_valid
  output logic        m_axis_tlast   // frame_done
);

  s5udp_pkg::in_item_t in_item;
  s5udp_pkg::in_item_t held_item;
  s5udp_pkg::result_t  res;
  s5udp_pkg::result_t  out_res;
  logic                held_valid;
  logic                can_load;
  logic                advance;
  logic                res_valid;

  assign in_item.rx_byte      = s_axis_tdata[7:0];
  assign in_item.buffer_limit = s_axis_tdata[24:8];
  assign in_item.last_byte    = s_axis_tlast;

  assign advance = held_valid && can_load;

  s5udp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .take       (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  s5udp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  s5udp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .can_load  (can_load),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {4'd0, out_res.copied_length, out_res.source_port,
                         out_res.source_address, out_res.frame_status,
                         out_res.payload_byte};
  assign m_axis_tuser = out_res.payload_valid;
  assign m_axis_tlast = out_res.frame_done;

endmodule
